/* src/dss_pkg.sv */
package dss_pkg;

  // Item kinds on the input channel
  localparam logic OP_READING = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Sides
  localparam logic SD_LEFT  = 1'b0;
  localparam logic SD_RIGHT = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MIN_DISTANCE = 2'd0;
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd1;
  localparam logic [1:0] REG_MIN_STRENGTH = 2'd2;
  localparam logic [1:0] REG_NOZZLE_OFS   = 2'd3;

  // Register reset values
  localparam logic [15:0] MIN_DISTANCE_RST = 16'd20;
  localparam logic [15:0] MAX_DISTANCE_RST = 16'd400;
  localparam logic [15:0] MIN_STRENGTH_RST = 16'd200;
  localparam logic [7:0]  NOZZLE_OFS_RST   = 8'd6;

  localparam int PENDING_W = 5;

  typedef struct packed {
    logic        opcode;
    logic        side;
    logic [15:0] distance_cm;
    logic [15:0] strength;
    logic [31:0] position;
  } in_item_t;

  typedef struct packed {
    logic                 left_spray;
    logic                 right_spray;
    logic [PENDING_W-1:0] left_pending;
    logic [PENDING_W-1:0] right_pending;
  } out_item_t;

  // Per-side command for one accepted beat
  typedef struct packed {
    logic        tick;
    logic        reading;
    logic        canopy;
    logic [31:0] position;
    logic [7:0]  offset;
  } side_cmd_t;

  // Per-side state as seen after the beat
  typedef struct packed {
    logic                 spray;
    logic [PENDING_W-1:0] pending;
  } side_stat_t;

endpackage

/* src/dss_side.sv */
module dss_side #(
  parameter int QUEUE_DEPTH = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dss_pkg::side_cmd_t cmd,
  output dss_pkg::side_stat_t stat_nxt
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Segment ring entries
  logic [31:0] seg_start_r [QUEUE_DEPTH];
  logic [31:0] seg_end_r   [QUEUE_DEPTH];
  logic        seg_open_r  [QUEUE_DEPTH];

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             inside_r, inside_nxt;
  logic [31:0]      begin_r, begin_nxt;
  logic             spray_r, spray_nxt;
  logic             last_open_r, last_open_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      wr_start;
  logic [31:0]      wr_end;
  logic             wr_open;
  logic             wr_keep_start;

  logic [31:0]      bound;
  logic [31:0]      begin_bound;
  logic [IDX_W-1:0] last_idx;
  logic             spray_on;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    idx_inc = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  assign bound       = cmd.position + 32'(cmd.offset);
  assign begin_bound = begin_r + 32'(cmd.offset);
  assign last_idx    = (tail_r == '0) ? IDX_LAST : tail_r - 1'b1;
  assign spray_on    = spray_r || (cmd.position >= seg_start_r[head_r]);

  // Work out queue and solenoid updates for this beat
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    inside_nxt    = inside_r;
    begin_nxt     = begin_r;
    spray_nxt     = spray_r;
    last_open_nxt = last_open_r;
    wr_en         = 1'b0;
    wr_idx        = tail_r;
    wr_start      = bound;
    wr_end        = bound;
    wr_open       = 1'b0;
    wr_keep_start = 1'b0;

    if (cmd.tick) begin
      if (count_r != '0) begin
        spray_nxt = spray_on;
        if (spray_on && !seg_open_r[head_r] && (cmd.position >= seg_end_r[head_r])) begin
          spray_nxt = 1'b0;
          head_nxt  = idx_inc(head_r);
          count_nxt = count_r - 1'b1;
        end
      end
    end else if (cmd.reading) begin
      if (cmd.canopy && !inside_r) begin
        // Open a new segment at the nozzle bound
        inside_nxt = 1'b1;
        begin_nxt  = cmd.position;
        wr_en      = 1'b1;
        wr_start   = bound;
        wr_end     = '0;
        wr_open    = 1'b1;
      end else if (!cmd.canopy && inside_r) begin
        inside_nxt = 1'b0;
        if (count_r != '0 && last_open_r) begin
          // Close the newest segment in place
          wr_en         = 1'b1;
          wr_idx        = last_idx;
          wr_keep_start = 1'b1;
          wr_end        = bound;
          wr_open       = 1'b0;
          last_open_nxt = 1'b0;
        end else begin
          // Fall back to a closed segment
          wr_en    = 1'b1;
          wr_start = begin_bound;
          wr_end   = bound;
          wr_open  = 1'b0;
        end
      end
      // A push advances the tail and drops the oldest entry when full
      if (wr_en && !wr_keep_start) begin
        tail_nxt      = idx_inc(tail_r);
        last_open_nxt = wr_open;
        if (count_r == CNT_FULL) begin
          head_nxt = idx_inc(head_r);
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  // Write the ring entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (!wr_keep_start) begin
        seg_start_r[wr_idx] <= wr_start;
      end
      seg_end_r[wr_idx]  <= wr_end;
      seg_open_r[wr_idx] <= wr_open;
    end
  end

  // Hold side control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      inside_r    <= 1'b0;
      begin_r     <= '0;
      spray_r     <= 1'b0;
      last_open_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      inside_r    <= inside_nxt;
      begin_r     <= begin_nxt;
      spray_r     <= spray_nxt;
      last_open_r <= last_open_nxt;
    end
  end

  assign stat_nxt.spray   = spray_nxt;
  assign stat_nxt.pending = dss_pkg::PENDING_W'(count_nxt);

endmodule

/* src/delayed_segment_spray_scheduler.sv */
// Delayed segment spray scheduler for a left and a right side.
// Input channel (in_valid, in_stall, in_data): one beat is either a range
// reading for one side or an actuation tick for both sides. A beat is taken
// on a clock edge with in_valid high and in_stall low.
// Result channel (out_valid, out_stall, out_data): every input beat yields
// exactly one result beat with both solenoid states and queue fill levels.
// The result of a beat taken at edge N is shown from edge N on and stays
// until the receiver lifts out_stall. Throughput is one beat per cycle while
// the receiver does not stall; the ring updates, the offset add and the
// position compares all fit between the input port and the result register.
// When the receiver stalls, the held result blocks the input (in_stall goes
// high) until that result is taken; the result register frees in the same
// cycle it is taken, so no bubble is added.
// Reset (rst_n low, synchronous) empties both queues, leaves canopy, turns
// both solenoids off, drops any pending result and loads the threshold
// registers with their defaults. Thresholds must be written over the APB port
// only while the block is idle (not enforced); reads return the stored value.
module delayed_segment_spray_scheduler #(
  parameter int QUEUE_DEPTH = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dss_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] min_distance_r;
  logic [15:0] max_distance_r;
  logic [15:0] min_strength_r;
  logic [7:0]  nozzle_ofs_r;

  logic               out_valid_r;
  dss_pkg::out_item_t out_data_r;

  logic                accept;
  logic                canopy;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  dss_pkg::side_cmd_t  left_cmd;
  dss_pkg::side_cmd_t  right_cmd;
  dss_pkg::side_stat_t left_stat;
  dss_pkg::side_stat_t right_stat;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Classify the reading as canopy
  assign canopy = (in_data.strength > min_strength_r) &&
                  (in_data.distance_cm >= min_distance_r) &&
                  (in_data.distance_cm <= max_distance_r);

  // Route the beat to each side
  always_comb begin
    left_cmd.tick      = accept && (in_data.opcode == dss_pkg::OP_TICK);
    left_cmd.reading   = accept && (in_data.opcode == dss_pkg::OP_READING) &&
                         (in_data.side == dss_pkg::SD_LEFT);
    left_cmd.canopy    = canopy;
    left_cmd.position  = in_data.position;
    left_cmd.offset    = nozzle_ofs_r;
    right_cmd          = left_cmd;
    right_cmd.reading  = accept && (in_data.opcode == dss_pkg::OP_READING) &&
                         (in_data.side == dss_pkg::SD_RIGHT);
  end

  dss_side #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (left_cmd),
    .stat_nxt (left_stat)
  );

  dss_side #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (right_cmd),
    .stat_nxt (right_stat)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.left_spray    <= left_stat.spray;
      out_data_r.right_spray   <= right_stat.spray;
      out_data_r.left_pending  <= left_stat.pending;
      out_data_r.right_pending <= right_stat.pending;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_distance_r <= dss_pkg::MIN_DISTANCE_RST;
      max_distance_r <= dss_pkg::MAX_DISTANCE_RST;
      min_strength_r <= dss_pkg::MIN_STRENGTH_RST;
      nozzle_ofs_r   <= dss_pkg::NOZZLE_OFS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dss_pkg::REG_MIN_DISTANCE: min_distance_r <= pwdata[15:0];
        dss_pkg::REG_MAX_DISTANCE: max_distance_r <= pwdata[15:0];
        dss_pkg::REG_MIN_STRENGTH: min_strength_r <= pwdata[15:0];
        dss_pkg::REG_NOZZLE_OFS:   nozzle_ofs_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      dss_pkg::REG_MIN_DISTANCE: prdata = {16'd0, min_distance_r};
      dss_pkg::REG_MAX_DISTANCE: prdata = {16'd0, max_distance_r};
      dss_pkg::REG_MIN_STRENGTH: prdata = {16'd0, min_strength_r};
      dss_pkg::REG_NOZZLE_OFS:   prdata = {24'd0, nozzle_ofs_r};
      default:                   prdata = '0;
    endcase
  end

endmodule

/* src/dss_checker.sv */
module dss_checker #(
  parameter int QUEUE_DEPTH = 24
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dss_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dss_pkg::out_item_t out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Every accepted beat shows a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // No new beat while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  // Fill levels stay within the ring
  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.left_pending <= QUEUE_DEPTH) &&
                  (out_data.right_pending <= QUEUE_DEPTH))
    else $error("pending count beyond queue depth");

  // A solenoid is only on while a segment is held
  a_spray_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.left_spray && out_data.left_pending == '0) &&
                  !(out_data.right_spray && out_data.right_pending == '0))
    else $error("solenoid on with an empty queue");

endmodule

bind delayed_segment_spray_scheduler dss_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/spray_schedule_checker.sv */
`timescale 1ns / 100ps

module spray_schedule_checker #(
  parameter int QDEPTH = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  dss_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  dss_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 results_owed
);

  // Threshold copies, updated from observed APB writes
  logic [15:0] win_lo;
  logic [15:0] win_hi;
  logic [15:0] str_floor;
  logic [7:0]  nozzle;

  // Per-side segment rings and canopy tracking
  logic [31:0] seg_lo   [2][QDEPTH];
  logic [31:0] seg_hi   [2][QDEPTH];
  logic        seg_open [2][QDEPTH];
  int          q_head   [2];
  int          q_tail   [2];
  int          q_fill   [2];
  logic        in_canopy [2];
  logic [31:0] canopy_pos [2];
  logic        spray_on [2];

  dss_pkg::out_item_t owed_status [$];

  // Append a segment, dropping the oldest one when the ring is full
  function automatic void push_segment(int sd, logic [31:0] lo, logic [31:0] hi, logic open);
    if (q_fill[sd] >= QDEPTH) begin
      q_head[sd] = (q_head[sd] + 1) % QDEPTH;
      q_fill[sd]--;
    end
    seg_lo[sd][q_tail[sd]]   = lo;
    seg_hi[sd][q_tail[sd]]   = hi;
    seg_open[sd][q_tail[sd]] = open;
    q_tail[sd] = (q_tail[sd] + 1) % QDEPTH;
    q_fill[sd]++;
  endfunction

  // Switch a solenoid on at the front start, off and pop at a closed end
  function automatic void advance_side(int sd, logic [31:0] pos);
    int f;
    if (q_fill[sd] == 0) return;
    f = q_head[sd];
    if (!spray_on[sd] && pos >= seg_lo[sd][f]) spray_on[sd] = 1'b1;
    if (spray_on[sd] && !seg_open[sd][f] && pos >= seg_hi[sd][f]) begin
      spray_on[sd] = 1'b0;
      q_head[sd] = (q_head[sd] + 1) % QDEPTH;
      q_fill[sd]--;
    end
  endfunction

  // Apply one input beat and return the status it should produce
  function automatic dss_pkg::out_item_t schedule_beat(dss_pkg::in_item_t it);
    dss_pkg::out_item_t r;
    int          sd;
    int          last;
    logic        hit;
    logic [31:0] bound;
    sd    = int'(it.side);
    bound = it.position + 32'(nozzle);
    hit   = (it.strength > str_floor) && (it.distance_cm >= win_lo) &&
            (it.distance_cm <= win_hi);
    if (it.opcode == dss_pkg::OP_READING) begin
      if (hit) begin
        if (!in_canopy[sd]) begin
          in_canopy[sd]  = 1'b1;
          canopy_pos[sd] = it.position;
          push_segment(sd, bound, 32'h0, 1'b1);
        end
      end else if (in_canopy[sd]) begin
        // Close the newest segment, or queue a closed one if it is not open
        last = (q_tail[sd] + QDEPTH - 1) % QDEPTH;
        in_canopy[sd] = 1'b0;
        if (q_fill[sd] != 0 && seg_open[sd][last]) begin
          seg_hi[sd][last]   = bound;
          seg_open[sd][last] = 1'b0;
        end else begin
          push_segment(sd, canopy_pos[sd] + 32'(nozzle), bound, 1'b0);
        end
      end
    end else begin
      advance_side(0, it.position);
      advance_side(1, it.position);
    end
    r.left_spray    = spray_on[0];
    r.right_spray   = spray_on[1];
    r.left_pending  = q_fill[0][dss_pkg::PENDING_W-1:0];
    r.right_pending = q_fill[1][dss_pkg::PENDING_W-1:0];
    return r;
  endfunction

  function automatic bit field_bad(string name, int unsigned want, int unsigned got);
    if (want != got)
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    return want != got;
  endfunction

  // Watch APB, input and result channels on every rising edge
  always @(posedge clk) begin
    dss_pkg::out_item_t want;
    logic [31:0] reg_val;
    bit          bad;
    if (!rst_n) begin
      win_lo    = dss_pkg::MIN_DISTANCE_RST;
      win_hi    = dss_pkg::MAX_DISTANCE_RST;
      str_floor = dss_pkg::MIN_STRENGTH_RST;
      nozzle    = dss_pkg::NOZZLE_OFS_RST;
      for (int s = 0; s < 2; s++) begin
        q_head[s]     = 0;
        q_tail[s]     = 0;
        q_fill[s]     = 0;
        in_canopy[s]  = 1'b0;
        canopy_pos[s] = 32'h0;
        spray_on[s]   = 1'b0;
        for (int e = 0; e < QDEPTH; e++) begin
          seg_lo[s][e]   = 32'h0;
          seg_hi[s][e]   = 32'h0;
          seg_open[s][e] = 1'b0;
        end
      end
      owed_status.delete();
      fail_count = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          dss_pkg::REG_MIN_DISTANCE: win_lo    = pwdata[15:0];
          dss_pkg::REG_MAX_DISTANCE: win_hi    = pwdata[15:0];
          dss_pkg::REG_MIN_STRENGTH: str_floor = pwdata[15:0];
          dss_pkg::REG_NOZZLE_OFS:   nozzle    = pwdata[7:0];
          default: ;
        endcase
      end
      // Check register reads
      if (psel && penable && !pwrite && pready) begin
        case (paddr[3:2])
          dss_pkg::REG_MIN_DISTANCE: reg_val = {16'h0, win_lo};
          dss_pkg::REG_MAX_DISTANCE: reg_val = {16'h0, win_hi};
          dss_pkg::REG_MIN_STRENGTH: reg_val = {16'h0, str_floor};
          default:                   reg_val = {24'h0, nozzle};
        endcase
        if (prdata !== reg_val) begin
          $display("%0t: register %0d read expected %h got %h", $time, paddr[3:2],
                   reg_val, prdata);
          fail_count++;
        end
      end
      // Predict each accepted input beat
      if (in_valid && !in_stall) owed_status.push_back(schedule_beat(in_data));
      // Compare each accepted result beat with the oldest expectation
      if (out_valid && !out_stall) begin
        if (owed_status.size() == 0) begin
          $display("%0t: result beat expected none got spray %b/%b pending %0d/%0d", $time,
                   out_data.left_spray, out_data.right_spray, out_data.left_pending,
                   out_data.right_pending);
          fail_count++;
        end else begin
          want = owed_status.pop_front();
          bad  = 1'b0;
          bad |= field_bad("left_spray", want.left_spray, out_data.left_spray);
          bad |= field_bad("right_spray", want.right_spray, out_data.right_spray);
          bad |= field_bad("left_pending", want.left_pending, out_data.left_pending);
          bad |= field_bad("right_pending", want.right_pending, out_data.right_pending);
          if (bad) fail_count++;
        end
      end
    end
    results_owed = owed_status.size();
  end

endmodule

/* bench/tb_delayed_segment_spray_scheduler.sv */
`timescale 1ns / 100ps

module tb_delayed_segment_spray_scheduler;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dss_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  dss_pkg::out_item_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int          fail_count;
  int          results_owed;
  int          cycle_count;

  // Threshold values last programmed, used to shape readings
  int unsigned win_lo;
  int unsigned win_hi;
  int unsigned str_floor;

  logic [31:0] travel;
  bit          want_canopy [2];
  bit          send_burst;
  bit          take_burst;
  bit          hold_req;

  delayed_segment_spray_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  spray_schedule_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL delayed_segment_spray_scheduler");
    $finish;
  end

  // Idle draws, with occasional stretches of back-to-back beats
  function automatic int send_gap();
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    return send_burst ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic int take_gap();
    if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
    return take_burst ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic dss_pkg::in_item_t beat_of(logic op, logic sd, logic [15:0] range_cm,
                                                logic [15:0] str, logic [31:0] pos);
    dss_pkg::in_item_t it;
    it.opcode      = op;
    it.side        = sd;
    it.distance_cm = range_cm;
    it.strength    = str;
    it.position    = pos;
    return it;
  endfunction

  // Build a reading that lands inside or outside the canopy window
  function automatic dss_pkg::in_item_t canopy_reading(logic sd, bit canopy, logic [31:0] pos);
    dss_pkg::in_item_t it;
    int       pick;
    it   = beat_of(dss_pkg::OP_READING, sd, 16'($urandom), 16'($urandom), pos);
    pick = $urandom_range(0, 3);
    if (canopy) begin
      if (win_lo <= win_hi && str_floor != 32'hFFFF) begin
        case (pick)
          0:       it.distance_cm = 16'(win_lo);
          1:       it.distance_cm = 16'(win_hi);
          default: it.distance_cm = 16'($urandom_range(win_hi, win_lo));
        endcase
        if (pick == 2) it.strength = 16'(str_floor + 1);
        else it.strength = 16'($urandom_range(32'hFFFF, str_floor + 1));
      end
    end else begin
      case (pick)
        0: it.strength = 16'($urandom_range(str_floor, 0));
        1: begin
          if (win_lo != 0) it.distance_cm = 16'($urandom_range(win_lo - 1, 0));
          else it.strength = 16'(str_floor);
        end
        default: begin
          if (win_hi != 32'hFFFF) it.distance_cm = 16'($urandom_range(32'hFFFF, win_hi + 1));
          else it.strength = 16'(str_floor);
        end
      endcase
    end
    return it;
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input dss_pkg::in_item_t it);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // One APB transfer; psel and penable are lowered by the caller
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result beat has been taken
  task automatic flush_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic program_thresholds(input int unsigned lo, input int unsigned hi,
                                    input int unsigned floor, input int unsigned ofs);
    flush_results();
    apb_access(1'b1, dss_pkg::REG_MIN_DISTANCE, lo);
    apb_access(1'b1, dss_pkg::REG_MAX_DISTANCE, hi);
    apb_access(1'b1, dss_pkg::REG_MIN_STRENGTH, floor);
    apb_access(1'b1, dss_pkg::REG_NOZZLE_OFS, ofs);
    apb_access(1'b0, dss_pkg::REG_MIN_DISTANCE, 32'h0);
    apb_access(1'b0, dss_pkg::REG_MAX_DISTANCE, 32'h0);
    apb_access(1'b0, dss_pkg::REG_MIN_STRENGTH, 32'h0);
    apb_access(1'b0, dss_pkg::REG_NOZZLE_OFS, 32'h0);
    psel    <= 1'b0;
    penable <= 1'b0;
    win_lo    = lo;
    win_hi    = hi;
    str_floor = floor;
  endtask

  // Mostly forward travel with canopy runs per side, plus ticks and noise
  task automatic random_run(input int n, input int tick_pct, input bit squeeze);
    dss_pkg::in_item_t it;
    int       roll;
    int       sd;
    for (int k = 0; k < n; k++) begin
      if (squeeze && k == 60) hold_req = 1'b1;
      travel = travel + 32'($urandom_range(0, 8));
      if ($urandom_range(0, 199) == 0) travel = 32'hFFFF_FF00 + 32'($urandom_range(0, 200));
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        it = beat_of(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else if (roll < 8 + tick_pct) begin
        it = beat_of(dss_pkg::OP_TICK, 1'($urandom), 16'($urandom), 16'($urandom), travel);
      end else begin
        sd = $urandom_range(0, 1);
        if ($urandom_range(0, 3) == 0) want_canopy[sd] = !want_canopy[sd];
        it = canopy_reading(1'(sd), want_canopy[sd], travel);
      end
      send_beat(it);
    end
  endtask

  // Result side: stall for a random gap before taking each beat
  initial begin
    int gap;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        gap      = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        gap = take_gap();
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int tick_pct [6];
    tick_pct = '{35, 30, 30, 2, 30, 45};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    win_lo     = dss_pkg::MIN_DISTANCE_RST;
    win_hi     = dss_pkg::MAX_DISTANCE_RST;
    str_floor  = dss_pkg::MIN_STRENGTH_RST;
    travel     = 32'h0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    hold_req   = 1'b0;
    want_canopy = '{1'b0, 1'b0};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats under reset thresholds
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_LEFT, 16'h0, 16'h0, 32'd0));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_LEFT, 16'd20, 16'd201, 32'd100));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_LEFT, 16'd400, 16'hFFFF, 32'd101));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_RIGHT, 16'hFFFF, 16'hFFFF, 32'd105));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_LEFT, 16'h0, 16'h0, 32'd106));
    // Open end never switches off
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_LEFT, 16'h0, 16'h0, 32'hFFFF_FFFF));
    // Strength equal to the minimum is not canopy
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_LEFT, 16'd20, 16'd200, 32'd120));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_LEFT, 16'd19, 16'd5000, 32'd121));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_LEFT, 16'h0, 16'h0, 32'd125));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_LEFT, 16'h0, 16'h0, 32'd126));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_RIGHT, 16'd400, 16'hFFFF, 32'd200));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_RIGHT, 16'd401, 16'hFFFF, 32'd210));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_RIGHT, 16'h0, 16'h0, 32'd211));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_RIGHT, 16'hFFFF, 16'hFFFF, 32'd212));
    // Segment bounds wrapping past zero
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_LEFT, 16'd300, 16'd1000,
                      32'hFFFF_FFFD));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_LEFT, 16'hFFFF, 16'd1000,
                      32'hFFFF_FFFE));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_LEFT, 16'h0, 16'h0, 32'hFFFF_FFFE));
    // Closed end at all ones is an ordinary end
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_RIGHT, 16'd300, 16'd1000,
                      32'hFFFF_FFF0));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_RIGHT, 16'd10, 16'd1000,
                      32'hFFFF_FFF9));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_RIGHT, 16'h0, 16'h0, 32'hFFFF_FFF8));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_RIGHT, 16'h0, 16'h0, 32'hFFFF_FFFE));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_RIGHT, 16'h0, 16'h0, 32'hFFFF_FFFF));
    // Both sides spraying from one tick
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_LEFT, 16'd50, 16'd300, 32'd1000));
    send_beat(beat_of(dss_pkg::OP_READING, dss_pkg::SD_RIGHT, 16'd50, 16'd300, 32'd1000));
    send_beat(beat_of(dss_pkg::OP_TICK, dss_pkg::SD_LEFT, 16'h0, 16'h0, 32'd1010));
    travel = 32'd1010;

    // Random phases over several threshold settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_thresholds(0, 32'hFFFF, 0, 32'hFF);
        1: program_thresholds(dss_pkg::MIN_DISTANCE_RST, dss_pkg::MAX_DISTANCE_RST,
                              dss_pkg::MIN_STRENGTH_RST, dss_pkg::NOZZLE_OFS_RST);
        2: program_thresholds(32'hFFFF, 32'hFFFF, 32'hFFFE, 0);
        4: program_thresholds(500, 100, 0, 128);
        default: begin
          win_lo = $urandom_range(0, 1000);
          program_thresholds(win_lo, win_lo + $urandom_range(0, 3000),
                             $urandom_range(0, 3000), $urandom_range(0, 255));
        end
      endcase
      random_run(300, tick_pct[ph], ph == 1);
    end

    flush_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS delayed_segment_spray_scheduler");
    end else begin
      $display("FAIL delayed_segment_spray_scheduler");
    end
    $finish;
  end

endmodule
